// ===== hw/rtl/skvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value store package
// Field widths and status codes shared by the store and its channels.
// ----------------------------------------------------------------------------
package skvs_pkg;

  localparam int unsigned FuncW  = 1;
  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_SET = 1'b0,
    FUNC_GET = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_HIT       = 2'd0,
    ST_INSERTED  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/skvs_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one set or get request word.
// ----------------------------------------------------------------------------
interface skvs_req_if;

  logic                        valid;
  logic                        ready;
  skvs_pkg::func_e             func;
  logic [skvs_pkg::KeyW-1:0]   key;
  logic [skvs_pkg::ValueW-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);

endinterface

// ===== hw/rtl/skvs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface skvs_rsp_if;

  logic                        valid;
  logic                        ready;
  logic [skvs_pkg::ValueW-1:0] read_value;
  skvs_pkg::status_e           status;
  logic [skvs_pkg::CountW-1:0] entry_count;

  modport source (output valid, output read_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input entry_count,
                  output ready);

endinterface

// ===== hw/rtl/skvs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skvs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/sorted_key_value_store_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value store
// Table of key/value pairs kept in ascending key order in one RAM.
// ----------------------------------------------------------------------------
// The store takes one request word at a time and is not ready while it works
// on it. A request walks the sorted table upwards one entry per cycle through
// the single RAM read port and one pair of key comparators (less and equal),
// and a get or an update gives its result once the walk stops at its entry;
// the next word is taken after the result has gone to the output register.
// An insert below the top entry then moves each larger entry up one slot, one
// per cycle through the same port, and then places the new pair. The result
// sits in an output register, so the next request is taken while it waits; a
// stalled receiver holds a second result in the sequencer, which then stops
// taking words. Keys are cut or zero-extended to KEY_BITS bits and
// entry_count reports the low five bits of the fill.
// ----------------------------------------------------------------------------
module sorted_key_value_store_unit #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  skvs_req_if.sink   req_i,
  skvs_rsp_if.source rsp_o
);

  localparam int unsigned AddrW = $clog2(ENTRIES);
  localparam int unsigned IdxW  = $clog2(ENTRIES + 1);
  localparam int unsigned DataW = KEY_BITS + skvs_pkg::ValueW;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_PLACE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  skvs_pkg::func_e               func_q, func_d;
  logic [KEY_BITS-1:0]           key_q, key_d;
  logic [skvs_pkg::ValueW-1:0]   value_q, value_d;
  logic [IdxW-1:0]               idx_q, idx_d;
  logic [IdxW-1:0]               slot_q, slot_d;
  logic [IdxW-1:0]               used_q, used_d;
  logic [skvs_pkg::ValueW-1:0]   res_value_q, res_value_d;
  skvs_pkg::status_e             res_status_q, res_status_d;

  logic                          rsp_valid_q, rsp_valid_d;
  logic [skvs_pkg::ValueW-1:0]   rsp_value_q, rsp_value_d;
  skvs_pkg::status_e             rsp_status_q, rsp_status_d;
  logic [skvs_pkg::CountW-1:0]   rsp_count_q, rsp_count_d;

  logic                          ram_we;
  logic [IdxW-1:0]               ram_widx;
  logic [DataW-1:0]              ram_wdata;
  logic [IdxW-1:0]               ram_ridx;
  logic [DataW-1:0]              ram_rdata;

  logic [KEY_BITS+skvs_pkg::KeyW-1:0] key_ext;
  logic [IdxW+skvs_pkg::CountW-1:0]   count_ext;
  logic [KEY_BITS-1:0]           rd_key;
  logic [skvs_pkg::ValueW-1:0]   rd_value;
  logic                          key_lt, key_eq;
  logic                          req_fire, rsp_free;

  assign key_ext   = {{KEY_BITS{1'b0}}, req_i.key};
  assign count_ext = {{skvs_pkg::CountW{1'b0}}, used_q};
  assign rd_key    = ram_rdata[DataW-1:skvs_pkg::ValueW];
  assign rd_value  = ram_rdata[skvs_pkg::ValueW-1:0];

  // The one key comparator pair (less and equal) that the whole walk shares.
  assign key_lt = rd_key < key_q;
  assign key_eq = rd_key == key_q;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    key_d        = key_q;
    value_d      = value_q;
    idx_d        = idx_q;
    slot_d       = slot_q;
    used_d       = used_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_widx     = idx_q;
    ram_wdata    = {key_q, value_q};
    ram_ridx     = idx_q;

    unique case (state_q)
      S_IDLE: begin
        ram_ridx = '0;
        if (req_fire) begin
          func_d  = req_i.func;
          key_d   = key_ext[KEY_BITS-1:0];
          value_d = req_i.value;
          idx_d   = '0;
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // Read data here belongs to entry idx_q; while the walk goes on, the read of idx_d is issued.
        if (idx_q != used_q && key_lt) begin
          idx_d    = idx_q + IdxW'(1);
          ram_ridx = idx_d;
        end else begin
          res_value_d = '0;
          state_d     = S_DONE;
          if (func_q == skvs_pkg::FUNC_GET) begin
            if (idx_q != used_q && key_eq) begin
              res_value_d  = rd_value;
              res_status_d = skvs_pkg::ST_HIT;
            end else begin
              res_status_d = skvs_pkg::ST_NOT_FOUND;
            end
          end else if (idx_q != used_q && key_eq) begin
            ram_we       = 1'b1;
            res_status_d = skvs_pkg::ST_HIT;
          end else if (used_q == IdxW'(ENTRIES)) begin
            res_status_d = skvs_pkg::ST_FULL;
          end else if (idx_q == used_q) begin
            ram_we       = 1'b1;
            used_d       = used_q + IdxW'(1);
            res_status_d = skvs_pkg::ST_INSERTED;
          end else begin
            // Larger entries move up, starting with the top one.
            slot_d   = idx_q;
            idx_d    = used_q;
            ram_ridx = used_q - IdxW'(1);
            state_d  = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        if (idx_q - IdxW'(1) == slot_q) begin
          state_d = S_PLACE;
        end else begin
          idx_d    = idx_q - IdxW'(1);
          ram_ridx = idx_q - IdxW'(2);
        end
      end
      S_PLACE: begin
        ram_we       = 1'b1;
        ram_widx     = slot_q;
        used_d       = used_q + IdxW'(1);
        res_value_d  = '0;
        res_status_d = skvs_pkg::ST_INSERTED;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d  = rsp_valid_q;
    rsp_value_d  = rsp_value_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    if (state_q == S_DONE && rsp_free) begin
      rsp_valid_d  = 1'b1;
      rsp_value_d  = res_value_q;
      rsp_status_d = res_status_q;
      rsp_count_d  = count_ext[skvs_pkg::CountW-1:0];
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    slot_q       <= slot_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    rsp_value_q  <= rsp_value_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
  end

  skvs_ram #(
    .WIDTH (DataW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_widx[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (ram_ridx[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_value  = rsp_value_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;

  // The fill never passes the table size.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= IdxW'(ENTRIES))
    else $error("fill count beyond table size");

  // The fill grows by one after placing a pair, and changes only on an insert.
  a_used_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PLACE |=> used_q == $past(used_q) + IdxW'(1))
    else $error("fill count not advanced on insert");

  a_used_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_PLACE && !(state_q == S_SEARCH && state_d == S_DONE &&
    res_status_d == skvs_pkg::ST_INSERTED) |=> $stable(used_q))
    else $error("fill count changed without an insert");

  // A refused set is only reported on a full table.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && res_status_q == skvs_pkg::ST_FULL |-> used_q == IdxW'(ENTRIES))
    else $error("full status on a table with room");

  // The move-up pass never writes at or below the insertion slot.
  a_shift_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SHIFT |-> idx_q > slot_q && idx_q <= used_q)
    else $error("move-up pass outside its range");

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Sorted key/value store testbench
// Drives set and get request words through the request channel with random
// gaps, holds its own sorted table to predict every response word, and
// compares each response field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;

  import skvs_pkg::*;

  localparam int          ClkPeriod   = 4;
  localparam int          ResetCycles = 11;
  localparam int unsigned Entries     = 16;
  localparam int          DrainCycles = 2 * Entries + 8;
  localparam int          HoldCycles  = 400;
  localparam int          CycleLimit  = 800_000;
  localparam int          PrintLimit  = 40;

  typedef struct packed {
    logic [ValueW-1:0] read_value;
    status_e           status;
    logic [CountW-1:0] entry_count;
  } store_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  skvs_req_if req_if ();
  skvs_rsp_if rsp_if ();

  sorted_key_value_store_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Predicted table, kept in ascending key order like the store itself.
  logic [KeyW-1:0]   model_keys   [Entries];
  logic [ValueW-1:0] model_values [Entries];
  int unsigned       model_fill;

  store_result_t pending_results [$];

  int error_count;
  int results_checked;
  int requests_sent;
  int inserts_seen, updates_seen, refusals_seen, hits_seen, misses_seen;
  int peak_fill;
  int hold_requests;
  int hold_served;
  bit sender_idles;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return KeyW'($urandom());
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom();
  endfunction

  function automatic bit key_is_stored(logic [KeyW-1:0] key);
    for (int unsigned i = 0; i < model_fill; i++) begin
      if (model_keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [KeyW-1:0] find_absent_key();
    logic [KeyW-1:0] key;
    key = KeyW'($urandom());
    while (key_is_stored(key)) key = KeyW'($urandom());
    return key;
  endfunction

  // Applies one request to the predicted table and returns the response word
  // that the store must give for it.
  function automatic store_result_t predict_store_access(func_e func, logic [KeyW-1:0] key,
                                                         logic [ValueW-1:0] value);
    store_result_t res;
    int unsigned   slot;
    int unsigned   j;
    bit            present;
    res.read_value = '0;
    slot = 0;
    while (slot < model_fill && model_keys[slot] < key) slot++;
    present = (slot < model_fill) && (model_keys[slot] == key);
    if (func == FUNC_SET) begin
      if (present) begin
        model_values[slot] = value;
        res.status = ST_HIT;
        updates_seen++;
      end else if (model_fill >= Entries) begin
        res.status = ST_FULL;
        refusals_seen++;
      end else begin
        for (j = model_fill; j > slot; j--) begin
          model_keys[j]   = model_keys[j-1];
          model_values[j] = model_values[j-1];
        end
        model_keys[slot]   = key;
        model_values[slot] = value;
        model_fill++;
        res.status = ST_INSERTED;
        inserts_seen++;
      end
    end else begin
      if (present) begin
        res.read_value = model_values[slot];
        res.status = ST_HIT;
        hits_seen++;
      end else begin
        res.status = ST_NOT_FOUND;
        misses_seen++;
      end
    end
    res.entry_count = CountW'(model_fill);
    if (model_fill > peak_fill) peak_fill = model_fill;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ValueW-1:0] got, logic [ValueW-1:0] want);
    error_count++;
    if (error_count <= PrintLimit) begin
      $display("MISMATCH %s at response %0d: got %h, expected %h",
               what, results_checked, got, want);
    end
  endtask

  // Offers one request word and returns at the edge that accepts it. Valid is
  // left high so that a back-to-back word follows without a gap.
  task automatic send_request(func_e func, logic [KeyW-1:0] key, logic [ValueW-1:0] value);
    int            gap;
    store_result_t expected;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= func;
    req_if.key   <= key;
    req_if.value <= value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected = predict_store_access(func, key, value);
    pending_results.insert(pending_results.size(), expected);
    requests_sent++;
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic run_random_requests(int count, int insert_pct);
    int              r;
    logic [KeyW-1:0] anchor;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) sender_idles = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (model_fill > 0) anchor = model_keys[$urandom_range(0, model_fill - 1)];
      else anchor = pick_key();
      if (r < insert_pct) begin
        send_request(FUNC_SET, pick_key(), pick_value());
      end else if (r < 40) begin
        send_request(FUNC_GET, anchor, $urandom());
      end else if (r < 62) begin
        send_request(FUNC_SET, anchor, pick_value());
      end else if (r < 74) begin
        // Neighbours of stored keys probe both sides of each comparison.
        send_request(FUNC_GET, r[0] ? KeyW'(anchor + 1) : KeyW'(anchor - 1), $urandom());
      end else if (r < 96) begin
        send_request(FUNC_GET, pick_key(), $urandom());
      end else begin
        send_request(FUNC_SET, r[0] ? KeyW'(anchor + 1) : KeyW'(anchor - 1), pick_value());
      end
    end
  endtask

  task automatic test_edge_keys();
    sender_idles = 1'b1;
    send_request(FUNC_GET, 16'h0000, 32'hFFFF_FFFF);
    send_request(FUNC_SET, 16'h8000, 32'hFFFF_FFFF);
    send_request(FUNC_SET, 16'h0000, 32'h0000_0000);
    send_request(FUNC_SET, 16'hFFFF, 32'hA5A5_A5A5);
    send_request(FUNC_GET, 16'h0000, 32'h0000_0000);
    send_request(FUNC_GET, 16'hFFFF, 32'h5A5A_5A5A);
    send_request(FUNC_GET, 16'h8000, 32'h0000_0000);
    send_request(FUNC_SET, 16'h8000, 32'h1234_5678);
    send_request(FUNC_GET, 16'h8000, 32'h0000_0000);
    send_request(FUNC_GET, 16'h0001, 32'h0000_0000);
    send_request(FUNC_GET, 16'hFFFE, 32'h0000_0000);
  endtask

  task automatic test_growing_table();
    run_random_requests(300, 4);
  endtask

  task automatic test_full_table();
    sender_idles = 1'b1;
    while (model_fill < Entries) send_request(FUNC_SET, find_absent_key(), pick_value());
    send_request(FUNC_SET, find_absent_key(), 32'hDEAD_BEEF);
    send_request(FUNC_SET, model_keys[Entries-1], 32'h0F0F_0F0F);
    send_request(FUNC_SET, model_keys[0], 32'hF0F0_F0F0);
    send_request(FUNC_GET, model_keys[0], 32'h0000_0000);
    send_request(FUNC_GET, model_keys[Entries-1], 32'h0000_0000);
    send_request(FUNC_GET, find_absent_key(), 32'hFFFF_FFFF);
  endtask

  // The receiver stops for a long stretch while words keep coming, so the
  // output register fills and the request channel stalls.
  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    hold_requests++;
    for (int n = 0; n < 12; n++) begin
      send_request(n[0] ? FUNC_GET : FUNC_SET, model_keys[$urandom_range(0, Entries - 1)],
                   pick_value());
    end
  endtask

  task automatic test_random_mix();
    run_random_requests(950, 6);
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.func  <= FUNC_SET;
    req_if.key   <= '0;
    req_if.value <= '0;
    model_fill    = 0;
    peak_fill     = 0;
    hold_requests = 0;
    sender_idles  = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_keys();
    test_growing_table();
    test_full_table();
    test_output_backpressure();
    wait_for_results();
    test_random_mix();
    wait_for_results();

    $display("Sent %0d requests and checked %0d responses: %0d inserts, %0d updates,",
             requests_sent, results_checked, inserts_seen, updates_seen);
    $display("%0d full refusals, %0d hits, %0d misses; table reached %0d of %0d entries.",
             refusals_seen, hits_seen, misses_seen, peak_fill, Entries);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches, and the long hold-off on request.
  initial begin
    int stall_left;
    int hold_left;
    int calm_left;
    rsp_if.ready <= 1'b0;
    stall_left  = 0;
    hold_left   = 0;
    calm_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HoldCycles;
      end
      if (calm_left > 0) calm_left--;
      else if ($urandom_range(0, 999) == 0) calm_left = $urandom_range(200, 1500);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if (calm_left > 0 || $urandom_range(0, 99) < 70) begin
        rsp_if.ready <= 1'b1;
      end else begin
        stall_left = pick_gap();
        rsp_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    store_result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected response", rsp_if.read_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.read_value !== want.read_value)
          report_mismatch("read_value", rsp_if.read_value, want.read_value);
        if (rsp_if.status !== want.status)
          report_mismatch("status", ValueW'(rsp_if.status), ValueW'(want.status));
        if (rsp_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", ValueW'(rsp_if.entry_count),
                          ValueW'(want.entry_count));
      end
      results_checked++;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timeout after %0d cycles with %0d responses outstanding",
             CycleLimit, pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule
